FILE: hdl/beast_binary_frame_encoder_core_macros.svh
// assertion macros shared by the encoder modules
`ifndef BEAST_BINARY_FRAME_ENCODER_CORE_MACROS_SVH
`define BEAST_BINARY_FRAME_ENCODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define BFE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// condition must never be seen outside reset
`define BFE_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define BFE_ASSERT(label, clk, rst_n, prop)
`define BFE_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: hdl/bfe_pkg.sv
package bfe_pkg;

	// field widths
	localparam int TIME_W = 48;
	localparam int CORR_W = 16;
	localparam int CFG_IDX_W = 2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FEED_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPORT_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEX_FORMAT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TIME    = 2'd3;

	// framing constants
	localparam logic [7:0]  ESC_BYTE     = 8'h1a;
	localparam logic [7:0]  TYPE_MODE_S  = 8'h33;
	localparam logic [7:0]  TYPE_MODE_AC = 8'h31;
	localparam logic [7:0]  STRENGTH_MAX = 8'd255;
	localparam logic [13:0] TICKS_PER_MS = 14'd12000;

	// command queue depth
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// command opcodes
	localparam logic [1:0] OP_HEARTBEAT = 2'd0;
	localparam logic [1:0] OP_HEX       = 2'd1;
	localparam logic [1:0] OP_BINARY    = 2'd2;

	typedef struct packed {
		logic                     kind;
		logic [7:0]               data_byte;
		logic                     first;
		logic                     last;
		logic [TIME_W-1:0]        time_ms;
		logic signed [CORR_W-1:0] correlation_whole;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} result_t;

	// one classified command between front and back
	typedef struct packed {
		logic [1:0]        op;
		logic [7:0]        data_byte;
		logic              first;
		logic              last;
		logic [7:0]        strength;
		logic [TIME_W-1:0] ts;
	} cmd_t;

endpackage

FILE: hdl/beast_binary_frame_encoder_core.sv
// Beast frame encoder: turns received Mode-S message bytes and heartbeat
// ticks into a Beast output byte stream (binary or hex text framing).
// Input channel: a beat is taken when push is high and full is low; each
// beat is one message byte or one heartbeat tick.
// Result channel: while empty is low the oldest output byte is on result;
// it is taken when pop is high. run_last flags the final byte caused by
// an input beat, frame_end the final byte of a whole frame.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, write
// only while the block is idle; cfg_ready is always high.
// The first output byte of a beat passes the two front stages, the command
// queue, the sequencer register and the output register.
// Throughput: one output byte per cycle while pop keeps the output register
// free; a beat makes one byte for a plain binary data byte, two when escaped,
// up to 18 with the binary header; the byte sequencer sets the rate.
// Beats that make no output are dropped in the front.
// When pop stays low the output register holds, the sequencer and the
// four-entry command queue fill, and full rises to stall the input.
// Reset clears all config registers to zero and empties every stage.
module beast_binary_frame_encoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  bfe_pkg::item_t                item,
	output logic                          empty,
	input  logic                          pop,
	output bfe_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfe_pkg::TIME_W-1:0]    cfg_data
);
	import bfe_pkg::*;

	logic cmd_valid;
	cmd_t cmd_in;
	logic cmd_full;
	logic head_valid;
	cmd_t head_cmd;
	logic head_pop;

	// classify and timestamp
	bfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	// decoupling queue
	bfe_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cmd_valid),
		.wr_cmd   (cmd_in),
		.q_full   (cmd_full),
		.rd_valid (head_valid),
		.rd_cmd   (head_cmd),
		.rd_pop   (head_pop)
	);

	// byte sequencer and output register
	bfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (head_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: hdl/bfe_front.sv
module bfe_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  bfe_pkg::item_t                  item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfe_pkg::TIME_W-1:0]      cfg_data,
	output logic                            cmd_valid,
	output bfe_pkg::cmd_t                   cmd,
	input  logic                            cmd_full
);
	import bfe_pkg::*;

	logic              feed_enable_q;
	logic              export_enable_q;
	logic              hex_format_q;
	logic [TIME_W-1:0] start_time_q;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [TIME_W-1:0] diff_s1;
	logic              valid_s2;
	cmd_t              cmd_s2;

	logic              adv1;
	logic              adv2;
	logic              accept;
	logic              keep;
	logic [1:0]        op_in;
	logic [7:0]        strength_in;
	logic [TIME_W+13:0] ts_prod;

	// config registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_enable_q   <= 1'b0;
			export_enable_q <= 1'b0;
			hex_format_q    <= 1'b0;
			start_time_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FEED_ENABLE:   feed_enable_q   <= cfg_data[0];
				CFG_EXPORT_ENABLE: export_enable_q <= cfg_data[0];
				CFG_HEX_FORMAT:    hex_format_q    <= cfg_data[0];
				CFG_START_TIME:    start_time_q    <= cfg_data;
			endcase
		end
	end

	// stall chain from the queue back to the input
	assign adv2   = !valid_s2 || !cmd_full;
	assign adv1   = !valid_s1 || adv2;
	assign full   = !adv1;
	assign accept = push && !full;

	// classify the beat; disabled beats are dropped here
	always_comb begin
		keep  = 1'b0;
		op_in = OP_BINARY;
		if (export_enable_q) begin
			if (item.kind) begin
				keep  = 1'b1;
				op_in = OP_HEARTBEAT;
			end else if (feed_enable_q) begin
				keep  = 1'b1;
				op_in = hex_format_q ? OP_HEX : OP_BINARY;
			end
		end
	end

	// signal strength clamped to 1..255
	always_comb begin
		if (item.correlation_whole > 16'sd255) begin
			strength_in = STRENGTH_MAX;
		end else if (item.correlation_whole < 16'sd1) begin
			strength_in = 8'd1;
		end else begin
			strength_in = item.correlation_whole[7:0];
		end
	end

	// stage 1: capture and subtract start time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1.op        <= op_in;
			cmd_s1.data_byte <= item.data_byte;
			cmd_s1.first     <= item.first;
			cmd_s1.last      <= item.last;
			cmd_s1.strength  <= strength_in;
			cmd_s1.ts        <= '0;
			diff_s1          <= item.time_ms - start_time_q;
		end
	end

	// stage 2: scale to 12 MHz ticks, keep low 48 bits
	assign ts_prod = diff_s1 * TICKS_PER_MS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			cmd_s2.op        <= cmd_s1.op;
			cmd_s2.data_byte <= cmd_s1.data_byte;
			cmd_s2.first     <= cmd_s1.first;
			cmd_s2.last      <= cmd_s1.last;
			cmd_s2.strength  <= cmd_s1.strength;
			cmd_s2.ts        <= ts_prod[TIME_W-1:0];
		end
	end

	assign cmd_valid = valid_s2;
	assign cmd       = cmd_s2;

endmodule

FILE: hdl/bfe_cmd_queue.sv
`include "beast_binary_frame_encoder_core_macros.svh"

module bfe_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	input  bfe_pkg::cmd_t wr_cmd,
	output logic          q_full,
	output logic          rd_valid,
	output bfe_pkg::cmd_t rd_cmd,
	input  logic          rd_pop
);
	import bfe_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full   = (count_q == QCNT_W'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && !q_full;
	assign do_rd    = rd_pop && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`BFE_ASSERT_NEVER(a_count_ovf, clk, arst_n, count_q > QCNT_W'(QDEPTH))
	`BFE_ASSERT(a_empty_ptrs, clk, arst_n, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
	`BFE_ASSERT(a_full_valid, clk, arst_n, q_full |-> rd_valid)

endmodule

FILE: hdl/bfe_back.sv
`include "beast_binary_frame_encoder_core_macros.svh"

module bfe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  bfe_pkg::cmd_t   cmd,
	output logic            cmd_pop,
	output logic            empty,
	input  logic            pop,
	output bfe_pkg::result_t result
);
	import bfe_pkg::*;

	// byte positions within a frame
	localparam logic [3:0] SLOT_HEAD   = 4'd0;
	localparam logic [3:0] SLOT_TYPE   = 4'd1;
	localparam logic [3:0] SLOT_ESC_LO = 4'd2;
	localparam logic [3:0] SLOT_STREN  = 4'd8;
	localparam logic [3:0] SLOT_DATA   = 4'd9;
	localparam logic [3:0] SLOT_HB_END = 4'd10;
	localparam logic [3:0] SLOT_HEX_HI = 4'd1;
	localparam logic [3:0] SLOT_HEX_LO = 4'd2;
	localparam logic [3:0] SLOT_HEX_SC = 4'd3;
	localparam logic [3:0] SLOT_HEX_NL = 4'd4;

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [3:0] slot_q;
	logic       dup_q;
	logic       out_valid_q;
	result_t    result_q;

	logic [7:0] cur_byte;
	logic       last_slot;
	logic       escapable;
	logic       esc_pend;
	logic       is_final;
	logic       advance;
	logic       load;
	logic [3:0] start_slot;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'b0, v}) : (8'h57 + {4'b0, v});
	endfunction

	// byte for the current slot
	always_comb begin
		cur_byte  = 8'h00;
		last_slot = 1'b1;
		escapable = 1'b0;
		unique case (cur_q.op)
			OP_HEARTBEAT: begin
				last_slot = (slot_q == SLOT_HB_END);
				if (slot_q == SLOT_HEAD) begin
					cur_byte = ESC_BYTE;
				end else if (slot_q == SLOT_TYPE) begin
					cur_byte = TYPE_MODE_AC;
				end
			end
			OP_HEX: begin
				last_slot = cur_q.last ? (slot_q == SLOT_HEX_NL) : (slot_q == SLOT_HEX_LO);
				unique case (slot_q)
					SLOT_HEAD:   cur_byte = 8'h2a;
					SLOT_HEX_HI: cur_byte = hex_digit(cur_q.data_byte[7:4]);
					SLOT_HEX_LO: cur_byte = hex_digit(cur_q.data_byte[3:0]);
					SLOT_HEX_SC: cur_byte = 8'h3b;
					SLOT_HEX_NL: cur_byte = 8'h0a;
					default:     cur_byte = 8'h00;
				endcase
			end
			OP_BINARY: begin
				last_slot = (slot_q == SLOT_DATA);
				escapable = (slot_q >= SLOT_ESC_LO);
				unique case (slot_q)
					4'd0:    cur_byte = ESC_BYTE;
					4'd1:    cur_byte = TYPE_MODE_S;
					4'd2:    cur_byte = cur_q.ts[47:40];
					4'd3:    cur_byte = cur_q.ts[39:32];
					4'd4:    cur_byte = cur_q.ts[31:24];
					4'd5:    cur_byte = cur_q.ts[23:16];
					4'd6:    cur_byte = cur_q.ts[15:8];
					4'd7:    cur_byte = cur_q.ts[7:0];
					4'd8:    cur_byte = cur_q.strength;
					4'd9:    cur_byte = cur_q.data_byte;
					default: cur_byte = 8'h00;
				endcase
			end
			default: begin
				cur_byte  = 8'h00;
				last_slot = 1'b1;
			end
		endcase
	end

	// escape doubling and end of run
	assign esc_pend = escapable && (cur_byte == ESC_BYTE) && !dup_q;
	assign is_final = last_slot && !esc_pend;
	assign advance  = cur_valid_q && (!out_valid_q || pop);
	assign load     = cmd_valid && (!cur_valid_q || (advance && is_final));
	assign cmd_pop  = load;

	// first slot of a new command
	always_comb begin
		unique case (cmd.op)
			OP_HEX:    start_slot = cmd.first ? SLOT_HEAD : SLOT_HEX_HI;
			OP_BINARY: start_slot = cmd.first ? SLOT_HEAD : SLOT_DATA;
			default:   start_slot = SLOT_HEAD;
		endcase
	end

	// sequencer over the slots of one command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			slot_q      <= '0;
			dup_q       <= 1'b0;
		end else if (load) begin
			cur_valid_q <= 1'b1;
			slot_q      <= start_slot;
			dup_q       <= 1'b0;
		end else if (advance) begin
			if (is_final) begin
				cur_valid_q <= 1'b0;
				dup_q       <= 1'b0;
			end else if (esc_pend) begin
				dup_q <= 1'b1;
			end else begin
				dup_q  <= 1'b0;
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= cmd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.out_byte  <= cur_byte;
			result_q.run_last  <= is_final;
			result_q.frame_end <= is_final && ((cur_q.op == OP_HEARTBEAT) || cur_q.last);
		end
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

	`BFE_ASSERT(a_dup_on_esc, clk, arst_n, dup_q |-> (cur_valid_q && (cur_byte == ESC_BYTE)))
	`BFE_ASSERT(a_final_ends, clk, arst_n, (advance && is_final && !load) |=> !cur_valid_q)
	`BFE_ASSERT_NEVER(a_slot_range, clk, arst_n, cur_valid_q && (slot_q > SLOT_HB_END))

endmodule

FILE: tb/tb_beast_binary_frame_encoder_core.sv
`timescale 1ns / 1ps

module tb_beast_binary_frame_encoder_core;
	import bfe_pkg::*;

	localparam logic KIND_MESSAGE   = 1'b0;
	localparam logic KIND_HEARTBEAT = 1'b1;

	// ascii characters of the hex text framing
	localparam logic [7:0] CHAR_STAR = 8'h2a;
	localparam logic [7:0] CHAR_SEMI = 8'h3b;
	localparam logic [7:0] CHAR_LF   = 8'h0a;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_A    = 8'h61;

	localparam logic [7:0]        STRENGTH_MIN    = 8'd1;
	localparam logic [TIME_W-1:0] TIME_MAX        = {TIME_W{1'b1}};
	localparam int                HEARTBEAT_ZEROS = 9;
	localparam int                DRAIN_CYCLES    = 12;
	localparam int                MAX_REPORTS     = 10;

	// expected output bytes and the register copy they are predicted from
	class frame_scoreboard;
		logic              feed_en   = 1'b0;
		logic              export_en = 1'b0;
		logic              hex_mode  = 1'b0;
		logic [TIME_W-1:0] start_ms  = '0;
		result_t           expected_q[$];
		int                errors    = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] d);
			case (idx)
				CFG_FEED_ENABLE:   feed_en = d[0];
				CFG_EXPORT_ENABLE: export_en = d[0];
				CFG_HEX_FORMAT:    hex_mode = d[0];
				CFG_START_TIME:    start_ms = d;
				default: ;
			endcase
		endfunction

		// tick count since the start time, wrapping like a 64-bit product
		function logic [TIME_W-1:0] stamp(logic [TIME_W-1:0] t);
			logic [63:0] ticks;
			ticks = {16'd0, t} - {16'd0, start_ms};
			ticks = ticks * 64'(TICKS_PER_MS);
			return ticks[TIME_W-1:0];
		endfunction

		function logic [7:0] hex_char(logic [3:0] v);
			if (v < 4'd10)
				return CHAR_ZERO + 8'(v);
			return CHAR_A + 8'(v) - 8'd10;
		endfunction

		function void note_item(item_t it);
			logic [7:0]               bytes[$];
			logic [7:0]               body[$];
			logic [TIME_W-1:0]        ts;
			logic signed [CORR_W-1:0] corr;
			logic [7:0]               strength;
			result_t                  r;
			if (!export_en)
				return;
			if (it.kind == KIND_HEARTBEAT) begin
				// fixed mode-ac frame
				bytes.push_back(ESC_BYTE);
				bytes.push_back(TYPE_MODE_AC);
				repeat (HEARTBEAT_ZEROS) bytes.push_back(8'h00);
			end else if (!feed_en) begin
				return;
			end else if (hex_mode) begin
				if (it.first)
					bytes.push_back(CHAR_STAR);
				bytes.push_back(hex_char(it.data_byte[7:4]));
				bytes.push_back(hex_char(it.data_byte[3:0]));
				if (it.last) begin
					bytes.push_back(CHAR_SEMI);
					bytes.push_back(CHAR_LF);
				end
			end else begin
				// binary header on the first byte, then escaped body
				if (it.first) begin
					ts = stamp(it.time_ms);
					corr = it.correlation_whole;
					if (corr > 16'sd255)
						strength = STRENGTH_MAX;
					else if (corr < 16'sd1)
						strength = STRENGTH_MIN;
					else
						strength = corr[7:0];
					bytes.push_back(ESC_BYTE);
					bytes.push_back(TYPE_MODE_S);
					for (int sh = 40; sh >= 0; sh -= 8)
						body.push_back(ts[sh +: 8]);
					body.push_back(strength);
				end
				body.push_back(it.data_byte);
				foreach (body[i]) begin
					bytes.push_back(body[i]);
					if (body[i] == ESC_BYTE)
						bytes.push_back(body[i]);
				end
			end
			foreach (bytes[i]) begin
				r.out_byte = bytes[i];
				r.run_last = (i == bytes.size() - 1);
				r.frame_end = r.run_last && (it.kind == KIND_HEARTBEAT || it.last);
				expected_q.push_back(r);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected byte %h run_last %b frame_end %b",
						got.out_byte, got.run_last, got.frame_end);
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
					got.frame_end !== want.frame_end) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch: expected %h/%b/%b got %h/%b/%b (byte/run_last/frame_end)",
						want.out_byte, want.run_last, want.frame_end,
						got.out_byte, got.run_last, got.frame_end);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	item_t                 in_item   = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	result_t               out_result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [TIME_W-1:0]     cfg_data  = '0;

	frame_scoreboard sb;
	int burst_left = 0;
	int sent_count = 0;

	beast_binary_frame_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (in_item),
		.empty     (empty),
		.pop       (pop),
		.result    (out_result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// beat monitor: results, inputs and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(out_result);
			if (push && !full)
				sb.note_item(in_item);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// receiver stalls: free running, random, sparse, and long holds
	int stall_mode = 0;
	int stall_span = 0;
	int hold_left  = 0;
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(30, 200);
		end else begin
			stall_span--;
		end
		case (stall_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			2: pop <= ($urandom_range(0, 3) == 0);
			default: begin
				if (hold_left > 0) begin
					hold_left--;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						hold_left = $urandom_range(5, 20);
				end
			end
		endcase
	end

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	function automatic logic signed [CORR_W-1:0] rand_corr();
		case ($urandom_range(0, 3))
			0: return CORR_W'($urandom);
			1: return CORR_W'($urandom_range(0, 300));
			2: begin
				case ($urandom_range(0, 5))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sd0;
					3: return 16'sd256;
					4: return -16'sd1;
					default: return 16'sd26;
				endcase
			end
			default: return CORR_W'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_data();
		if ($urandom_range(0, 7) == 0)
			return ESC_BYTE;
		return 8'($urandom);
	endfunction

	function automatic item_t mk_item(logic kind, logic [7:0] data, logic first, logic last,
			logic [TIME_W-1:0] t, logic signed [CORR_W-1:0] corr);
		item_t it;
		it.kind = kind;
		it.data_byte = data;
		it.first = first;
		it.last = last;
		it.time_ms = t;
		it.correlation_whole = corr;
		return it;
	endfunction

	// sender: bursts of beats with random gaps between them
	task automatic send_item(input item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
		end
		push <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		burst_left--;
		sent_count++;
	endtask

	task automatic send_heartbeat();
		send_item(mk_item(KIND_HEARTBEAT, 8'($urandom), 1'($urandom), 1'($urandom),
			rand48(), CORR_W'($urandom)));
	endtask

	// one message, now and then with a flag dropped or a heartbeat inside
	task automatic send_message(input int len);
		logic drop_first;
		logic drop_last;
		drop_first = ($urandom_range(0, 9) == 0);
		drop_last = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < len; i++) begin
			send_item(mk_item(KIND_MESSAGE, rand_data(), (i == 0) && !drop_first,
				(i == len - 1) && !drop_last, rand48(), rand_corr()));
			if ($urandom_range(0, 30) == 0)
				send_heartbeat();
		end
	endtask

	// wait until every expected byte is out and the front has drained
	task automatic settle();
		push <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic fe, input logic ex, input logic hx,
			input logic [TIME_W-1:0] st);
		cfg_beat(CFG_FEED_ENABLE, TIME_W'(fe));
		cfg_beat(CFG_EXPORT_ENABLE, TIME_W'(ex));
		cfg_beat(CFG_HEX_FORMAT, TIME_W'(hx));
		cfg_beat(CFG_START_TIME, st);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                base;
		int                quota;
		int                len;
		logic              found;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] ts;
		logic [TIME_W-1:0] st;
		sb = new;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: everything is dropped
		send_item(mk_item(KIND_HEARTBEAT, 8'h00, 1'b0, 1'b0, '0, '0));
		send_item(mk_item(KIND_MESSAGE, 8'h5a, 1'b1, 1'b1, '0, 16'sd100));
		settle();

		// binary framing, start time zero
		set_config(1'b1, 1'b1, 1'b0, '0);
		send_item(mk_item(KIND_HEARTBEAT, 8'hff, 1'b1, 1'b1, TIME_MAX, 16'sh7fff));
		send_item(mk_item(KIND_MESSAGE, 8'h00, 1'b1, 1'b0, '0, 16'sh8000));
		send_item(mk_item(KIND_MESSAGE, ESC_BYTE, 1'b0, 1'b0, TIME_MAX, '0));
		send_item(mk_item(KIND_MESSAGE, 8'hff, 1'b0, 1'b1, '0, '0));
		send_item(mk_item(KIND_MESSAGE, ESC_BYTE, 1'b1, 1'b1, TIME_MAX, 16'sh7fff));
		// heartbeat inside an open message
		send_item(mk_item(KIND_MESSAGE, 8'h8d, 1'b1, 1'b0, 48'd1, 16'sd0));
		send_item(mk_item(KIND_HEARTBEAT, 8'h00, 1'b0, 1'b0, '0, '0));
		send_item(mk_item(KIND_MESSAGE, 8'h42, 1'b0, 1'b1, '0, '0));
		// strength clamp edges, and a strength equal to the escape byte
		send_item(mk_item(KIND_MESSAGE, 8'h11, 1'b1, 1'b1, 48'd1000, 16'sd26));
		send_item(mk_item(KIND_MESSAGE, 8'h22, 1'b1, 1'b1, 48'd2000, 16'sd255));
		send_item(mk_item(KIND_MESSAGE, 8'h33, 1'b1, 1'b1, 48'd3000, 16'sd256));
		send_item(mk_item(KIND_MESSAGE, 8'h44, 1'b1, 1'b1, 48'd4000, 16'sd1));
		// byte with no first before it
		send_item(mk_item(KIND_MESSAGE, 8'h7e, 1'b0, 1'b0, TIME_MAX, 16'sh8000));
		// timestamp holding an escape byte
		found = 1'b0;
		while (!found) begin
			t = rand48();
			ts = sb.stamp(t);
			for (int k = 0; k < 6; k++)
				if (ts[8 * k +: 8] == ESC_BYTE)
					found = 1'b1;
		end
		send_item(mk_item(KIND_MESSAGE, 8'h99, 1'b1, 1'b1, t, 16'sd50));
		settle();

		// start time at its maximum: earlier times wrap
		set_config(1'b1, 1'b1, 1'b0, TIME_MAX);
		send_item(mk_item(KIND_MESSAGE, 8'h01, 1'b1, 1'b1, '0, 16'sd10));
		send_item(mk_item(KIND_MESSAGE, 8'h02, 1'b1, 1'b1, TIME_MAX, 16'sd10));
		settle();

		// hex text framing
		set_config(1'b1, 1'b1, 1'b1, rand48());
		send_item(mk_item(KIND_MESSAGE, 8'hab, 1'b1, 1'b0, rand48(), 16'sd5));
		send_item(mk_item(KIND_MESSAGE, 8'h09, 1'b0, 1'b0, rand48(), 16'sd5));
		send_item(mk_item(KIND_MESSAGE, 8'hf0, 1'b0, 1'b1, rand48(), 16'sd5));
		send_item(mk_item(KIND_MESSAGE, ESC_BYTE, 1'b1, 1'b1, rand48(), 16'sd5));
		send_heartbeat();
		settle();

		// export off: nothing comes out
		set_config(1'b1, 1'b0, 1'b1, '0);
		send_item(mk_item(KIND_MESSAGE, 8'h55, 1'b1, 1'b1, '0, 16'sd5));
		send_heartbeat();
		settle();

		// feed off: heartbeats only
		set_config(1'b0, 1'b1, 1'b0, '0);
		send_item(mk_item(KIND_MESSAGE, 8'h55, 1'b1, 1'b1, '0, 16'sd5));
		send_heartbeat();
		settle();

		// random phases, each under its own settings
		for (int p = 0; p < 9; p++) begin
			case ($urandom_range(0, 3))
				0: st = '0;
				1: st = TIME_MAX;
				default: st = rand48();
			endcase
			if (p == 3) begin
				set_config(1'($urandom), 1'b0, 1'($urandom), st);
				quota = 15;
			end else if (p == 6) begin
				set_config(1'b0, 1'b1, 1'($urandom), st);
				quota = 20;
			end else begin
				set_config(1'b1, 1'b1, 1'(p % 2), st);
				quota = 48;
			end
			base = sent_count;
			while (sent_count - base < quota) begin
				case ($urandom_range(0, 9))
					7: send_heartbeat();
					8, 9: send_item(mk_item(1'($urandom), 8'($urandom), 1'($urandom),
						1'($urandom), rand48(), CORR_W'($urandom)));
					default: begin
						if ($urandom_range(0, 3) != 0)
							len = ($urandom_range(0, 1) != 0) ? 7 : 14;
						else
							len = $urandom_range(1, 20);
						send_message(len);
					end
				endcase
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
